// ===== design/hspm_pkg.sv =====
// hspm_pkg: shared types, register codes and the EQ table for the port manager
// no dependencies; imported by the front, queue, back and top-level modules
`timescale 1ns / 1ps
`default_nettype none

package hspm_pkg;

  // switch register map
  localparam logic [7:0] REG_PORT   = 8'h0f;
  localparam logic [7:0] REG_OUTPUT = 8'h20;
  localparam logic [7:0] OUT_ON     = 8'h0f;
  localparam logic [7:0] OUT_OFF    = 8'h03;
  localparam logic [7:0] NULL_PORT  = 8'h03;

  // port code of the null port
  localparam logic [1:0] NULL_PORT_IDX = 2'd3;

  // configuration register indexes
  localparam int          CFG_IDX_W     = 1;
  localparam logic [0:0]  CFG_DELTA_MIN = 1'b0;
  localparam logic [0:0]  CFG_4K_THRESH = 1'b1;

  // reset values of the configuration registers
  localparam logic [7:0] DELTA_MIN_RST = 8'd2;
  localparam logic [7:0] THRESH_4K_RST = 8'd72;

  // EQ table index width (table holds 12 words)
  localparam int EQ_IDX_W = 4;

  // work plan of one item, handed from the front to the back
  typedef struct packed {
    logic       null_wr;      // all ports gone: write null port
    logic       sw;           // port switch sequence
    logic [1:0] sw_port;      // port to switch to
    logic       zero_off;     // clock dropped to zero: output off
    logic       eq;           // EQ table write sequence
    logic [1:0] active_port;  // status after the item
    logic [2:0] mask;
    logic       four_k;
    logic [7:0] clock;
  } plan_t;

  // EQ table register addresses
  function automatic logic [7:0] eq_addr(input logic [EQ_IDX_W-1:0] idx);
    logic [7:0] a;
    case (idx)
      4'd0:    a = 8'h11;
      4'd1:    a = 8'h12;
      4'd2:    a = 8'h13;
      4'd3:    a = 8'h14;
      4'd4:    a = 8'h16;
      4'd5:    a = 8'h18;
      4'd6:    a = 8'h19;
      4'd7:    a = 8'h1E;
      4'd8:    a = 8'h21;
      4'd9:    a = 8'h22;
      4'd10:   a = 8'h25;
      4'd11:   a = 8'h26;
      default: a = 8'h00;
    endcase
    return a;
  endfunction

  // EQ table register values
  function automatic logic [7:0] eq_data(input logic [EQ_IDX_W-1:0] idx);
    logic [7:0] d;
    case (idx)
      4'd0:    d = 8'h2F;
      4'd1:    d = 8'h00;
      4'd2:    d = 8'h40;
      4'd3:    d = 8'h00;
      4'd4:    d = 8'h40;
      4'd5:    d = 8'h00;
      4'd6:    d = 8'h66;
      4'd7:    d = 8'h0B;
      4'd8:    d = 8'h7F;
      4'd9:    d = 8'h79;
      4'd10:   d = 8'h30;
      4'd11:   d = 8'h51;
      default: d = 8'h00;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== design/hspm_front.sv =====
// hspm_front: accepts service items, tracks port/clock state, builds the work plan
// depends on hspm_pkg
`timescale 1ns / 1ps
`default_nettype none

module hspm_front #(
  parameter int PORT_COUNT = 3
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_requested_port,
  input  wire logic [7:0]                    in_rx_power_raw,
  input  wire logic [7:0]                    in_clock_normal,
  input  wire logic [7:0]                    in_clock_half,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [hspm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                    cfg_wdata,
  // plan queue
  output logic                               q_push,
  input  wire logic                          q_ready,
  output hspm_pkg::plan_t                    q_plan
);
  import hspm_pkg::*;

  localparam logic [1:0] LAST_PORT = 2'(PORT_COUNT - 1);

  logic [7:0] delta_r, thresh_r;
  logic [2:0] mask_r, mask_nxt;
  logic [1:0] active_r, active_nxt;
  logic [7:0] clock_r, clock_nxt;
  logic       fourk_r, fourk_nxt;

  logic [2:0] now, added, removed;
  logic [3:0] now4, rm4;
  logic [1:0] p;
  logic       found;
  logic [7:0] sel;
  logic       null_wr, sw, zero_off, eq;
  logic [7:0] base, f1, diff;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // classify one item against the current state
  always_comb begin
    now        = in_rx_power_raw[2:0];
    now4       = {1'b0, now};
    added      = ~mask_r & now;
    removed    = mask_r & ~now;
    rm4        = {1'b0, removed};
    mask_nxt   = mask_r;
    active_nxt = active_r;
    sel        = in_requested_port;
    null_wr    = 1'b0;
    p          = active_r;
    found      = 1'b0;
    // 5V tracking and round-robin search after losing the active port
    if (now != mask_r) begin
      mask_nxt = now;
      if (added == 3'b000 && rm4[active_r]) begin
        for (int i = 0; i < PORT_COUNT; i++) begin
          if (!found) begin
            p = (p == LAST_PORT) ? 2'd0 : p + 2'd1;
            if (now4[p]) found = 1'b1;
          end
        end
        if (found) begin
          sel = {6'b0, p};
        end else begin
          active_nxt = NULL_PORT_IDX;
          null_wr    = 1'b1;
          sel        = {6'b0, NULL_PORT_IDX};
        end
      end
    end
    // port switch
    sw = (sel != {6'b0, active_nxt}) && (sel < 8'(PORT_COUNT));
    if (sw) active_nxt = sel[1:0];
    base = sw ? 8'd0 : clock_r;
    // clock check, stuck clock reads as zero
    f1        = (in_clock_normal == in_clock_half) ? 8'd0 : in_clock_normal;
    diff      = (f1 >= base) ? f1 - base : base - f1;
    clock_nxt = base;
    fourk_nxt = fourk_r;
    zero_off  = 1'b0;
    eq        = 1'b0;
    if (diff >= delta_r) begin
      clock_nxt = f1;
      if (f1 == 8'd0) begin
        zero_off = 1'b1;
      end else begin
        fourk_nxt = (f1 > thresh_r);
        eq        = 1'b1;
      end
    end
  end

  // plan handed to the back
  always_comb begin
    q_plan.null_wr     = null_wr;
    q_plan.sw          = sw;
    q_plan.sw_port     = sel[1:0];
    q_plan.zero_off    = zero_off;
    q_plan.eq          = eq;
    q_plan.active_port = active_nxt;
    q_plan.mask        = mask_nxt;
    q_plan.four_k      = fourk_nxt;
    q_plan.clock       = clock_nxt;
  end

  // state update on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= 3'b000;
      active_r <= NULL_PORT_IDX;
      clock_r  <= 8'd0;
      fourk_r  <= 1'b0;
    end else if (q_push) begin
      mask_r   <= mask_nxt;
      active_r <= active_nxt;
      clock_r  <= clock_nxt;
      fourk_r  <= fourk_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_r  <= DELTA_MIN_RST;
      thresh_r <= THRESH_4K_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DELTA_MIN: delta_r  <= cfg_wdata;
        CFG_4K_THRESH: thresh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/hspm_queue.sv =====
// hspm_queue: two-entry plan queue between the front and the back
// depends on hspm_pkg
`timescale 1ns / 1ps
`default_nettype none

module hspm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  output logic                 push_ready,
  input  hspm_pkg::plan_t      push_plan,
  output logic                 pop_valid,
  input  wire logic            pop,
  output hspm_pkg::plan_t      pop_plan
);
  import hspm_pkg::*;

  plan_t      entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_plan   = entry_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_plan;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/hspm_back.sv =====
// hspm_back: walks each plan's write slots and drives the registered result channel
// depends on hspm_pkg
`timescale 1ns / 1ps
`default_nettype none

module hspm_back #(
  parameter int EQ_WORDS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // plan queue
  input  wire logic        q_valid,
  output logic             q_pop,
  input  hspm_pkg::plan_t  q_plan,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_write_valid,
  output logic [7:0]       out_reg_addr,
  output logic [7:0]       out_reg_data,
  output logic             out_last,
  output logic [1:0]       out_active_port_out,
  output logic [2:0]       out_connected_mask_out,
  output logic             out_is_4k,
  output logic [7:0]       out_clock_out
);
  import hspm_pkg::*;

  // slot layout: null, switch x4, zero-clock off, eq off, eq table, eq on
  localparam int NSLOT      = EQ_WORDS + 8;
  localparam int SLOT_W     = $clog2(NSLOT);
  localparam int S_NULL     = 0;
  localparam int S_SW_OFF   = 1;
  localparam int S_SW_NULL  = 2;
  localparam int S_SW_PORT  = 3;
  localparam int S_SW_ON    = 4;
  localparam int S_ZERO     = 5;
  localparam int S_EQ_OFF   = 6;
  localparam int S_EQ_FIRST = 7;
  localparam int S_EQ_ON    = EQ_WORDS + 7;

  logic              busy_r;
  plan_t             plan_r;
  logic [SLOT_W-1:0] slot_r;
  logic              out_valid_r;

  plan_t             cur;
  logic [NSLOT-1:0]  en;
  logic [SLOT_W-1:0] first, cur_slot, nxt_slot;
  logic              has_nxt, last, emit, out_free;
  logic [7:0]        wa, wd;
  logic [EQ_IDX_W-1:0] eq_idx;

  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;
  assign emit      = (busy_r || q_valid) && out_free;
  assign q_pop     = emit && !busy_r;
  assign cur       = busy_r ? plan_r : q_plan;

  // enabled slots of the current plan
  always_comb begin
    en = '0;
    en[S_NULL]    = cur.null_wr;
    en[S_SW_OFF]  = cur.sw;
    en[S_SW_NULL] = cur.sw;
    en[S_SW_PORT] = cur.sw;
    en[S_SW_ON]   = cur.sw;
    en[S_ZERO]    = cur.zero_off;
    for (int i = S_EQ_OFF; i < NSLOT; i++) en[i] = cur.eq;
  end

  // first and next enabled slot
  always_comb begin
    first   = '0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (en[i]) first = SLOT_W'(i);
    end
    cur_slot = busy_r ? slot_r : first;
    nxt_slot = '0;
    has_nxt  = 1'b0;
    for (int i = NSLOT - 1; i >= 0; i--) begin
      if (en[i] && SLOT_W'(i) > cur_slot) begin
        nxt_slot = SLOT_W'(i);
        has_nxt  = 1'b1;
      end
    end
    last = !has_nxt;
  end

  // slot to register write
  always_comb begin
    eq_idx = EQ_IDX_W'(cur_slot - SLOT_W'(S_EQ_FIRST));
    wa = 8'h00;
    wd = 8'h00;
    if (cur_slot == SLOT_W'(S_NULL)) begin
      wa = REG_PORT;   wd = NULL_PORT;
    end else if (cur_slot == SLOT_W'(S_SW_OFF)) begin
      wa = REG_OUTPUT; wd = OUT_OFF;
    end else if (cur_slot == SLOT_W'(S_SW_NULL)) begin
      wa = REG_PORT;   wd = NULL_PORT;
    end else if (cur_slot == SLOT_W'(S_SW_PORT)) begin
      wa = REG_PORT;   wd = {6'b0, cur.sw_port};
    end else if (cur_slot == SLOT_W'(S_SW_ON)) begin
      wa = REG_OUTPUT; wd = OUT_ON;
    end else if (cur_slot == SLOT_W'(S_ZERO) || cur_slot == SLOT_W'(S_EQ_OFF)) begin
      wa = REG_OUTPUT; wd = OUT_OFF;
    end else if (cur_slot == SLOT_W'(S_EQ_ON)) begin
      wa = REG_OUTPUT; wd = OUT_ON;
    end else begin
      wa = eq_addr(eq_idx);
      wd = eq_data(eq_idx);
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        busy_r      <= !last;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // plan hold and output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      plan_r                 <= cur;
      slot_r                 <= nxt_slot;
      out_write_valid        <= |en;
      out_reg_addr           <= (|en) ? wa : 8'h00;
      out_reg_data           <= (|en) ? wd : 8'h00;
      out_last               <= last;
      out_active_port_out    <= cur.active_port;
      out_connected_mask_out <= cur.mask;
      out_is_4k              <= cur.four_k;
      out_clock_out          <= cur.clock;
    end
  end

endmodule

`default_nettype wire

// ===== design/hdmi_switch_port_manager.sv =====
// hdmi_switch_port_manager: top level, front classifier, plan queue and write sequencer
// depends on hspm_pkg, hspm_front, hspm_queue, hspm_back
//
// Usage:
// Each item on the in_ channel (valid/ready) is one service poll: requested port,
// raw 5V status byte and the normal and half clock samples. Every register write the poll causes
// leaves on the out_ channel (valid/ready) as one item, with out_last on the final
// one; a poll that causes no write yields a single item with out_write_valid low.
// Status fields on every result show the state after the whole poll.
// The first result of an accepted poll is held in the plan queue, then registered at the output.
// A poll causing n writes (at most 18: port switch plus EQ table) occupies the write
// sequencer for its results; the sequencer emits one write per cycle while the receiver
// accepts them, and takes the next poll from the queue after a last result is emitted.
// The front takes a new poll every cycle while the two-entry plan queue has room.
// cfg_ is a plain write port (index 0: clock delta minimum, 1: 4K threshold); the user
// must write it only while the block is idle, which the block itself does not enforce.
// Reset (rst_n low, synchronous) empties the queue and output register, sets the null
// port, clears mask, clock and 4K flag and restores register defaults.
// A stalled receiver holds the current result; the queue then fills and in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module hdmi_switch_port_manager #(
  parameter int PORT_COUNT = 3,
  parameter int EQ_WORDS   = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_requested_port,
  input  wire logic [7:0]                     in_rx_power_raw,
  input  wire logic [7:0]                     in_clock_normal,
  input  wire logic [7:0]                     in_clock_half,
  input  wire logic                           cfg_wr_en,
  input  wire logic [hspm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_wdata,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_write_valid,
  output logic [7:0]                          out_reg_addr,
  output logic [7:0]                          out_reg_data,
  output logic                                out_last,
  output logic [1:0]                          out_active_port_out,
  output logic [2:0]                          out_connected_mask_out,
  output logic                                out_is_4k,
  output logic [7:0]                          out_clock_out
);
  import hspm_pkg::*;

  logic  push, push_ready, pop_valid, pop;
  plan_t push_plan, pop_plan;

  // front: accept and classify
  hspm_front #(.PORT_COUNT(PORT_COUNT)) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_requested_port (in_requested_port),
    .in_rx_power_raw   (in_rx_power_raw),
    .in_clock_normal   (in_clock_normal),
    .in_clock_half     (in_clock_half),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .q_push            (push),
    .q_ready           (push_ready),
    .q_plan            (push_plan)
  );

  // plan queue
  hspm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .push_plan  (push_plan),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_plan   (pop_plan)
  );

  // back: write sequencer
  hspm_back #(.EQ_WORDS(EQ_WORDS)) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .q_valid                (pop_valid),
    .q_pop                  (pop),
    .q_plan                 (pop_plan),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_write_valid        (out_write_valid),
    .out_reg_addr           (out_reg_addr),
    .out_reg_data           (out_reg_data),
    .out_last               (out_last),
    .out_active_port_out    (out_active_port_out),
    .out_connected_mask_out (out_connected_mask_out),
    .out_is_4k              (out_is_4k),
    .out_clock_out          (out_clock_out)
  );

endmodule

`default_nettype wire

// ===== design/hspm_checker.sv =====
// hspm_checker: port-level assertions for the port manager, bound to the top level
// depends on hdmi_switch_port_manager ports only
`timescale 1ns / 1ps
`default_nettype none

module hspm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_write_valid,
  input wire logic [7:0] out_reg_addr,
  input wire logic [7:0] out_reg_data,
  input wire logic       out_last,
  input wire logic [1:0] out_active_port_out,
  input wire logic [7:0] out_clock_out
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a no-write result is the only result of its item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_last)
    else $error("no-write result not marked last");

  // a no-write result carries zero address and data
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_reg_addr == 8'h00 && out_reg_data == 8'h00)
    else $error("no-write result carries payload");

  // writes of one item follow without a gap
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid)
    else $error("gap inside a write burst");

  // status is constant across the writes of one item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      $stable(out_active_port_out) && $stable(out_clock_out))
    else $error("status changed inside an item");

endmodule

bind hdmi_switch_port_manager hspm_checker u_hspm_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_write_valid     (out_write_valid),
  .out_reg_addr        (out_reg_addr),
  .out_reg_data        (out_reg_data),
  .out_last            (out_last),
  .out_active_port_out (out_active_port_out),
  .out_clock_out       (out_clock_out)
);

`default_nettype wire

// ===== test/hdmi_switch_port_manager_test.sv =====
// hdmi_switch_port_manager_test: self-checking bench for the HDMI switch port manager
// drives service polls and register settings, predicts every switch write and status
// depends on hspm_pkg and hdmi_switch_port_manager
`timescale 1ns / 1ps
`default_nettype none

module hdmi_switch_port_manager_test;
  import hspm_pkg::*;

  localparam int N_PORTS     = 3;
  localparam int N_EQ        = 12;
  localparam int N_DIRECTED  = 21;
  localparam int N_PHASES    = 5;
  localparam int PHASE_POLLS = 52;
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // EQ table, word 0 in the low byte
  localparam logic [N_EQ*8-1:0] EQ_ADDRS = {8'h26, 8'h25, 8'h22, 8'h21, 8'h1E, 8'h19,
                                            8'h18, 8'h16, 8'h14, 8'h13, 8'h12, 8'h11};
  localparam logic [N_EQ*8-1:0] EQ_DATAS = {8'h51, 8'h30, 8'h79, 8'h7F, 8'h0B, 8'h66,
                                            8'h00, 8'h40, 8'h00, 8'h40, 8'h00, 8'h2F};

  // one result item: a switch register write plus status after the poll
  typedef struct packed {
    logic       write_valid;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
    logic       last;
    logic [1:0] active_port;
    logic [2:0] mask;
    logic       four_k;
    logic [7:0] clock;
  } sw_write_t;

  // one row of the directed table; want is used only when typed is set
  typedef struct packed {
    logic [7:0] req;
    logic [7:0] pwr;
    logic [7:0] clk_n;
    logic [7:0] clk_h;
    logic       typed;
    sw_write_t  want;
  } poll_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [7:0]           in_requested_port = '0;
  logic [7:0]           in_rx_power_raw = '0;
  logic [7:0]           in_clock_normal = '0;
  logic [7:0]           in_clock_half = '0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_wdata = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_write_valid;
  logic [7:0]           out_reg_addr;
  logic [7:0]           out_reg_data;
  logic                 out_last;
  logic [1:0]           out_active_port_out;
  logic [2:0]           out_connected_mask_out;
  logic                 out_is_4k;
  logic [7:0]           out_clock_out;

  hdmi_switch_port_manager DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_requested_port      (in_requested_port),
    .in_rx_power_raw        (in_rx_power_raw),
    .in_clock_normal        (in_clock_normal),
    .in_clock_half          (in_clock_half),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_write_valid        (out_write_valid),
    .out_reg_addr           (out_reg_addr),
    .out_reg_data           (out_reg_data),
    .out_last               (out_last),
    .out_active_port_out    (out_active_port_out),
    .out_connected_mask_out (out_connected_mask_out),
    .out_is_4k              (out_is_4k),
    .out_clock_out          (out_clock_out)
  );

  always #2 clk = ~clk;

  // predictor state and register copies
  logic [2:0] pm_mask = 3'b000;
  logic [1:0] pm_port = NULL_PORT_IDX;
  logic [7:0] pm_clock = 8'd0;
  logic       pm_4k = 1'b0;
  logic [7:0] delta_min = DELTA_MIN_RST;
  logic [7:0] thresh_4k = THRESH_4K_RST;

  // writes of the poll being predicted, then its result items
  logic [7:0] pend_addr [19];
  logic [7:0] pend_data [19];
  int         pend_n;
  sw_write_t  poll_results[$];
  sw_write_t  expected_writes[$];

  int mismatches = 0;
  int burst_left = 0;

  function automatic void note_write(input logic [7:0] addr, input logic [7:0] data);
    pend_addr[pend_n] = addr;
    pend_data[pend_n] = data;
    pend_n++;
  endfunction

  // work out the writes and status caused by one service poll
  function automatic void predict_poll(input logic [7:0] req, input logic [7:0] pwr,
                                       input logic [7:0] clk_n, input logic [7:0] clk_h);
    int unsigned sel;
    int          p;
    logic        found;
    logic [2:0]  now;
    logic [2:0]  added;
    logic [2:0]  removed;
    logic [7:0]  f1;
    logic [7:0]  diff;
    logic        eq_need;
    sw_write_t   r;
    sel = 32'(req);
    now = pwr[2:0];
    eq_need = 1'b0;
    pend_n = 0;
    // 5V tracking, round-robin search when the active port loses power
    if (now != pm_mask) begin
      added = ~pm_mask & now;
      removed = pm_mask & ~now;
      pm_mask = now;
      if (added == 3'b000 && pm_port != NULL_PORT_IDX && removed[pm_port]) begin
        p = 32'(pm_port);
        found = 1'b0;
        for (int i = 0; i < N_PORTS; i++) begin
          p++;
          if (p >= N_PORTS) p = 0;
          if (!found && pm_mask[p]) begin
            sel = p;
            found = 1'b1;
          end
        end
        if (!found) begin
          pm_port = NULL_PORT_IDX;
          note_write(REG_PORT, NULL_PORT);
          sel = 32'(NULL_PORT_IDX);
        end
      end
    end
    // port switch sequence
    if (sel != pm_port && sel < N_PORTS) begin
      pm_port = sel[1:0];
      note_write(REG_OUTPUT, OUT_OFF);
      note_write(REG_PORT, NULL_PORT);
      note_write(REG_PORT, sel[7:0]);
      note_write(REG_OUTPUT, OUT_ON);
      pm_clock = 8'd0;
    end
    // clock check, a stuck reading counts as zero
    f1 = (clk_n == clk_h) ? 8'd0 : clk_n;
    diff = (f1 >= pm_clock) ? f1 - pm_clock : pm_clock - f1;
    if (diff >= delta_min) begin
      pm_clock = f1;
      if (f1 == 8'd0) begin
        note_write(REG_OUTPUT, OUT_OFF);
      end else begin
        pm_4k = (f1 > thresh_4k);
        eq_need = 1'b1;
      end
    end
    // EQ table framed by output off and on
    if (eq_need) begin
      note_write(REG_OUTPUT, OUT_OFF);
      for (int i = 0; i < N_EQ; i++) note_write(EQ_ADDRS[i*8 +: 8], EQ_DATAS[i*8 +: 8]);
      note_write(REG_OUTPUT, OUT_ON);
    end
    // result items, status after the whole poll on each
    poll_results.delete();
    for (int k = 0; k < ((pend_n > 0) ? pend_n : 1); k++) begin
      r.write_valid = (pend_n > 0);
      r.reg_addr = (pend_n > 0) ? pend_addr[k] : 8'd0;
      r.reg_data = (pend_n > 0) ? pend_data[k] : 8'd0;
      r.last = (k == ((pend_n > 0) ? pend_n : 1) - 1);
      r.active_port = pm_port;
      r.mask = pm_mask;
      r.four_k = pm_4k;
      r.clock = pm_clock;
      poll_results.push_back(r);
    end
  endfunction

  function automatic poll_row_t poll_row(input logic [7:0] req, input logic [7:0] pwr,
                                         input logic [7:0] clk_n, input logic [7:0] clk_h);
    poll_row_t row;
    row = '0;
    row.req = req;
    row.pwr = pwr;
    row.clk_n = clk_n;
    row.clk_h = clk_h;
    return row;
  endfunction

  // row whose single result is written out by hand
  function automatic poll_row_t poll_row_chk(input logic [7:0] req, input logic [7:0] pwr,
                                             input logic [7:0] clk_n, input logic [7:0] clk_h,
                                             input logic wv, input logic [7:0] addr,
                                             input logic [7:0] data, input logic [1:0] port,
                                             input logic [2:0] mask, input logic fk,
                                             input logic [7:0] clock);
    poll_row_t row;
    row = poll_row(req, pwr, clk_n, clk_h);
    row.typed = 1'b1;
    row.want = '{wv, addr, data, 1'b1, port, mask, fk, clock};
    return row;
  endfunction

  // offer one poll, in bursts with random gaps; returns at the accepting edge
  task automatic offer_poll(input poll_row_t row);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      case ($urandom_range(0, 9))
        0, 1:    gap = 0;
        2, 3, 4, 5, 6: gap = $urandom_range(1, 3);
        7, 8:    gap = $urandom_range(4, 12);
        default: gap = $urandom_range(20, 40);
      endcase
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_requested_port <= row.req;
    in_rx_power_raw <= row.pwr;
    in_clock_normal <= row.clk_n;
    in_clock_half <= row.clk_h;
    do @(posedge clk); while (!in_ready);
  endtask

  // send a poll and queue what it should produce
  task automatic run_poll(input poll_row_t row);
    offer_poll(row);
    predict_poll(row.req, row.pwr, row.clk_n, row.clk_h);
    if (row.typed) begin
      expected_writes.push_back(row.want);
    end else begin
      foreach (poll_results[k]) expected_writes.push_back(poll_results[k]);
    end
  endtask

  // stop offering and let every expected write come out
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [7:0] delta, input logic [7:0] thresh);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_DELTA_MIN;
    cfg_wdata <= delta;
    @(posedge clk);
    cfg_index <= CFG_4K_THRESH;
    cfg_wdata <= thresh;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delta_min = delta;
    thresh_4k = thresh;
  endtask

  // stimulus: directed table, then random phases under several settings
  initial begin
    poll_row_t  rows [N_DIRECTED];
    logic [7:0] ph_delta [N_PHASES];
    logic [7:0] ph_thresh [N_PHASES];
    logic [2:0] plugs;
    logic [7:0] line_clk;
    logic [7:0] rq;
    logic [7:0] pw;
    logic [7:0] cn;
    logic [7:0] ch;
    logic       stuck;

    // from reset: null port, no 5V, clock 0, delta 2, threshold 72
    rows[0]  = poll_row_chk(8'd3, 8'h00, 8'd0, 8'd0,
                            1'b0, 8'h00, 8'h00, NULL_PORT_IDX, 3'b000, 1'b0, 8'd0);
    rows[1]  = poll_row_chk(8'd255, 8'hF8, 8'hFF, 8'hFF,
                            1'b0, 8'h00, 8'h00, NULL_PORT_IDX, 3'b000, 1'b0, 8'd0);
    rows[2]  = poll_row(8'd0, 8'h01, 8'd80, 8'd40);
    rows[3]  = poll_row_chk(8'd0, 8'h01, 8'd81, 8'd40,
                            1'b0, 8'h00, 8'h00, 2'd0, 3'b001, 1'b1, 8'd80);
    rows[4]  = poll_row(8'd1, 8'h03, 8'd72, 8'd36);
    // stuck clock drops the recorded clock to zero: output off only
    rows[5]  = poll_row_chk(8'd3, 8'h03, 8'd50, 8'd50,
                            1'b1, REG_OUTPUT, OUT_OFF, 2'd1, 3'b011, 1'b0, 8'd0);
    rows[6]  = poll_row(8'd1, 8'h07, 8'd255, 8'd0);
    // active port loses 5V, search finds the next connected one
    rows[7]  = poll_row(8'd3, 8'h05, 8'd255, 8'd0);
    rows[8]  = poll_row_chk(8'd2, 8'h05, 8'd0, 8'd1,
                            1'b1, REG_OUTPUT, OUT_OFF, 2'd2, 3'b101, 1'b1, 8'd0);
    rows[9]  = poll_row(8'd3, 8'h01, 8'd0, 8'd0);
    // last port removed: null port write, request forced to none
    rows[10] = poll_row_chk(8'd3, 8'h00, 8'd0, 8'd0,
                            1'b1, REG_PORT, NULL_PORT, NULL_PORT_IDX, 3'b000, 1'b1, 8'd0);
    rows[11] = poll_row(8'd0, 8'h02, 8'd0, 8'd0);
    rows[12] = poll_row(8'd2, 8'h06, 8'd3, 8'd4);
    // change of exactly the delta counts, one less does not
    rows[13] = poll_row(8'd2, 8'h06, 8'd5, 8'd4);
    rows[14] = poll_row_chk(8'd2, 8'h06, 8'd4, 8'd5,
                            1'b0, 8'h00, 8'h00, 2'd2, 3'b110, 1'b0, 8'd5);
    // a non-active port going away changes only the mask
    rows[15] = poll_row_chk(8'd3, 8'h04, 8'd5, 8'd4,
                            1'b0, 8'h00, 8'h00, 2'd2, 3'b100, 1'b0, 8'd5);
    rows[16] = poll_row_chk(8'd0, 8'h00, 8'd5, 8'd4,
                            1'b1, REG_PORT, NULL_PORT, NULL_PORT_IDX, 3'b000, 1'b0, 8'd5);
    rows[17] = poll_row(8'd1, 8'h03, 8'd200, 8'd100);
    // ports added and removed in one poll: no search
    rows[18] = poll_row(8'd0, 8'h04, 8'd200, 8'd100);
    rows[19] = poll_row(8'd128, 8'hFF, 8'h55, 8'hAA);
    rows[20] = poll_row(8'd2, 8'h07, 8'hAA, 8'h55);

    ph_delta[0] = 8'd0;   ph_thresh[0] = 8'd0;
    ph_delta[1] = 8'd255; ph_thresh[1] = 8'd255;
    ph_delta[2] = 8'd1;   ph_thresh[2] = 8'd128;
    ph_delta[3] = 8'($urandom_range(0, 255));
    ph_thresh[3] = 8'($urandom_range(0, 255));
    ph_delta[4] = DELTA_MIN_RST; ph_thresh[4] = THRESH_4K_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) run_poll(rows[r]);
    settle();

    plugs = 3'b000;
    line_clk = 8'd0;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_regs(ph_delta[ph], ph_thresh[ph]);
      for (int n = 0; n < PHASE_POLLS; n++) begin
        // cable plug and unplug, mostly one port at a time
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: plugs = plugs ^ (3'b001 << $urandom_range(0, 2));
          6:       plugs = 3'b000;
          7:       plugs = 3'($urandom_range(0, 7));
          default: ;
        endcase
        pw = 8'($urandom);
        pw[2:0] = plugs;
        // mostly no switch request, then valid ports, then any byte
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9: rq = {6'd0, NULL_PORT_IDX};
          10, 11, 12, 13, 14, 15, 16:   rq = 8'($urandom_range(0, N_PORTS - 1));
          default:                      rq = 8'($urandom_range(0, 255));
        endcase
        // clock: steady with jitter, new timing, extremes, stuck, zero, noise
        stuck = 1'b0;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: cn = 8'(line_clk + $urandom_range(0, 2) - 1);
          9, 10, 11, 12: begin
            line_clk = 8'($urandom);
            cn = line_clk;
          end
          13, 14: begin
            line_clk = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            cn = line_clk;
          end
          15, 16: begin
            cn = 8'($urandom);
            stuck = 1'b1;
          end
          17, 18:  cn = 8'd0;
          default: cn = 8'($urandom);
        endcase
        if (stuck) ch = cn;
        else ch = $urandom_range(0, 3) != 0 ? (cn >> 1) : 8'($urandom);
        run_poll(poll_row(rq, pw, cn, ch));
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("hdmi_switch_port_manager_test: done, clean");
    end else begin
      $display("hdmi_switch_port_manager_test: done, errors");
    end
    $finish;
  end

  // receiver: rotating stall patterns, plus long hold-offs while polls keep coming
  int rcv_cycle = 0;
  int hold_left = 0;
  int polls_seen = 0;

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      polls_seen++;
      if (polls_seen == 60 || polls_seen == 200) hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case ((rcv_cycle / 97) % 4)
        0:       out_ready <= 1'b1;
        1:       out_ready <= (rcv_cycle % 4) != 0;
        2:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= (rcv_cycle % 7) < 2;
      endcase
    end
    rcv_cycle++;
  end

  // result checker and stall watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin : check_writes
    sw_write_t got;
    sw_write_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_write_valid, out_reg_addr, out_reg_data, out_last, out_active_port_out,
              out_connected_mask_out, out_is_4k, out_clock_out};
      if (expected_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result item: wv=%0d addr=%h data=%h last=%0d", got.write_valid,
                   got.reg_addr, got.reg_data, got.last);
      end else begin
        want = expected_writes.pop_front();
        if (got.write_valid !== want.write_valid || got.reg_addr !== want.reg_addr ||
            got.reg_data !== want.reg_data || got.last !== want.last ||
            got.active_port !== want.active_port || got.mask !== want.mask ||
            got.four_k !== want.four_k || got.clock !== want.clock) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch at %0t: expected wv=%0d addr=%h data=%h last=%0d",
                     $realtime, want.write_valid, want.reg_addr, want.reg_data, want.last);
            $display("  port=%0d mask=%b 4k=%0d clock=%0d", want.active_port, want.mask,
                     want.four_k, want.clock);
            $display("  got wv=%0d addr=%h data=%h last=%0d port=%0d mask=%b 4k=%0d clock=%0d",
                     got.write_valid, got.reg_addr, got.reg_data, got.last, got.active_port,
                     got.mask, got.four_k, got.clock);
          end
        end
      end
    end
    // no item moved on either side this cycle
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("hdmi_switch_port_manager_test: done, errors");
      $finish;
    end
  end

endmodule

`default_nettype wire
